[hdl/frame_parser_crc16_top_defines.svh]
// Assertion helpers for the checker file.
`ifndef FRAME_PARSER_CRC16_TOP_DEFINES_SVH
`define FRAME_PARSER_CRC16_TOP_DEFINES_SVH

// Same-cycle implication, idle while reset is high.
`define FP_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, idle while reset is high.
`define FP_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

[hdl/fp_crc16_pkg.sv]
`timescale 1ns / 1ps
package fp_crc16_pkg;

  localparam logic [3:0]  FRAME_LEN   = 4'd10;
  localparam logic [3:0]  CRC_BYTES   = 4'd8;
  localparam logic [3:0]  IDX_START   = 4'd0;
  localparam logic [3:0]  IDX_COMMAND = 4'd1;
  localparam logic [3:0]  IDX_SEQ_END = 4'd4;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [7:0]  START_BYTE_RESET = 8'd2;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_START_BYTE = '0;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_TOO_SHORT,
    STATUS_BAD_START,
    STATUS_CRC_MISMATCH
  } frame_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic [7:0]    command;
    logic [15:0]   sequence_res;
    logic [31:0]   payload_value;
  } out_word_t;

endpackage

[hdl/fp_crc16_update.sv]
`timescale 1ns / 1ps
module fp_crc16_update
  import fp_crc16_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc_out
);

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[hdl/frame_parser_crc16_top.sv]
`timescale 1ns / 1ps
// channel | handshake         | payload    | meaning
// in      | in_valid/in_ready | in_data    | one received byte, last marks end of buffer
// out     | out_valid/out_ready | out_data | status and fields of one frame
// cfg     | psel/penable/pwrite | paddr, pwdata, prdata | start byte register
//
// One byte is taken every cycle while in_ready is high; the byte-wise CRC update and
// field capture sit between the input handshake and the state and result registers.
// A frame result appears in the cycle after its last byte is taken.
// A waiting result stalls input only while out_ready is low.
// Synchronous reset returns all frame state and start_byte to reset values.
module frame_parser_crc16_top
  import fp_crc16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]  start_byte;
  logic [3:0]  byte_index;
  logic [15:0] running_crc;
  logic        start_ok;
  logic [7:0]  command_reg;
  logic [15:0] sequence_reg;
  logic [31:0] value_reg;
  logic [15:0] received_crc;

  logic [3:0]  byte_index_next;
  logic [15:0] running_crc_next;
  logic        start_ok_next;
  logic [7:0]  command_reg_next;
  logic [15:0] sequence_reg_next;
  logic [31:0] value_reg_next;
  logic [15:0] received_crc_next;
  logic [15:0] crc_step;
  out_word_t   result;
  logic        accept;
  logic        reg_hit;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[ADDR_W-1:2] == REG_START_BYTE);
  assign prdata   = reg_hit ? {24'd0, start_byte} : 32'd0;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      start_byte <= pwdata[7:0];
    end
  end

  fp_crc16_update u_crc (
    .crc_in  (running_crc),
    .byte_in (in_data.data_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    byte_index_next   = byte_index;
    running_crc_next  = running_crc;
    start_ok_next     = start_ok;
    command_reg_next  = command_reg;
    sequence_reg_next = sequence_reg;
    value_reg_next    = value_reg;
    received_crc_next = received_crc;
    // bytes past the tenth leave the frame untouched
    if (byte_index < FRAME_LEN) begin
      byte_index_next = byte_index + 4'd1;
      if (byte_index == IDX_START) begin
        start_ok_next = (in_data.data_byte == start_byte);
      end else if (byte_index == IDX_COMMAND) begin
        command_reg_next = in_data.data_byte;
      end else if (byte_index < IDX_SEQ_END) begin
        sequence_reg_next = {sequence_reg[7:0], in_data.data_byte};
      end else if (byte_index < CRC_BYTES) begin
        value_reg_next = {value_reg[23:0], in_data.data_byte};
      end else begin
        received_crc_next = {received_crc[7:0], in_data.data_byte};
      end
      if (byte_index < CRC_BYTES) begin
        running_crc_next = crc_step;
      end
    end
  end

  always_comb begin
    result.command       = command_reg_next;
    result.sequence_res  = sequence_reg_next;
    result.payload_value = value_reg_next;
    if (byte_index_next < FRAME_LEN) begin
      result.frame_status = STATUS_TOO_SHORT;
    end else if (!start_ok_next) begin
      result.frame_status = STATUS_BAD_START;
    end else if (received_crc_next != running_crc_next) begin
      result.frame_status = STATUS_CRC_MISMATCH;
    end else begin
      result.frame_status = STATUS_OK;
    end
    if (result.frame_status == STATUS_TOO_SHORT || result.frame_status == STATUS_BAD_START) begin
      result.command       = '0;
      result.sequence_res  = '0;
      result.payload_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      // rearm for the next buffer
      byte_index   <= '0;
      running_crc  <= CRC_INIT;
      start_ok     <= 1'b0;
      command_reg  <= '0;
      sequence_reg <= '0;
      value_reg    <= '0;
      received_crc <= '0;
    end else if (accept) begin
      byte_index   <= byte_index_next;
      running_crc  <= running_crc_next;
      start_ok     <= start_ok_next;
      command_reg  <= command_reg_next;
      sequence_reg <= sequence_reg_next;
      value_reg    <= value_reg_next;
      received_crc <= received_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= in_data.last_byte;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

endmodule

[hdl/fp_crc16_checker.sv]
`timescale 1ns / 1ps
`include "frame_parser_crc16_top_defines.svh"
module fp_crc16_checker
  import fp_crc16_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic in_take;
  logic fail_status;
  logic fields_zero;

  assign in_take     = in_valid && in_ready;
  assign fail_status = (out_data.frame_status == STATUS_TOO_SHORT) ||
                       (out_data.frame_status == STATUS_BAD_START);
  assign fields_zero = (out_data.command == 8'd0) && (out_data.sequence_res == 16'd0) &&
                       (out_data.payload_value == 32'd0);

  `FP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `FP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `FP_ASSERT_NEXT(a_last_gives_word, clk, rst, in_take && in_data.last_byte, out_valid)
  `FP_ASSERT_NEXT(a_mid_no_word, clk, rst, in_take && !in_data.last_byte, !out_valid)
  `FP_ASSERT_NOW(a_fail_fields_zero, clk, rst, out_valid && fail_status, fields_zero)

endmodule

bind frame_parser_crc16_top fp_crc16_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
